// File: sv/nzda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nzda_pkg;

    localparam int LINE_MAX   = 128;
    localparam int LINE_LIMIT = LINE_MAX - 4;
    localparam int POS_W      = $clog2(LINE_MAX);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int OUT_W      = 64;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LFX    = 8'h66;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_D      = 8'h44;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNKNOWN  = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_NOFIX    = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // one queued action for the line engine
    typedef struct packed {
        logic       pre_cr;
        logic       has_char;
        logic       is_end;
        logic [7:0] data;
    } evt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       xsum;
        logic             star;
        logic [7:0]       rsum;
        logic             hdr_ok;
        logic             no_fix;
        logic             ovf;
        logic [23:0]      time_bcd;
        logic [6:0]       day;
        logic [6:0]       month;
        logic [13:0]      year;
        logic             field_run;
        logic             hex_run;
    } line_t;

    function automatic line_t line_reset();
        line_t s;
        s = '0;
        s.hdr_ok = 1'b1;
        return s;
    endfunction

    function automatic logic [7:0] head_char(logic [2:0] p);
        logic [7:0] r;
        case (p)
            3'd0:    r = CH_DOLLAR;
            3'd1:    r = CH_G;
            3'd2:    r = CH_P;
            3'd3:    r = CH_Z;
            3'd4:    r = CH_D;
            3'd5:    r = CH_UA;
            default: r = CH_COMMA;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] bcd2bin(logic [7:0] b);
        return 7'({3'b0, b[7:4]} * 7'd10) + {3'b0, b[3:0]};
    endfunction

    function automatic line_t take_char(line_t s_in, logic [7:0] c);
        line_t            s;
        logic [POS_W-1:0] p;
        logic             is_digit;
        logic [3:0]       d;
        logic [4:0]       h;
        s        = s_in;
        p        = s_in.pos;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d        = c[3:0];
        h        = 5'd16;
        if (p >= POS_W'(LINE_LIMIT)) begin
            s.ovf = 1'b1;
        end
        else begin
            if ((p < POS_W'(7)) && (c != head_char(p[2:0])))
                s.hdr_ok = 1'b0;
            if ((p == POS_W'(7)) && (c == CH_COMMA))
                s.no_fix = 1'b1;

            if (s.star) begin
                if (is_digit)
                    h = {1'b0, d};
                else if (((c >= CH_UA) && (c <= CH_UF)) || ((c >= CH_LA) && (c <= CH_LFX)))
                    h = {1'b0, c[3:0] + 4'd9};
                if (s.hex_run && !h[4])
                    s.rsum = {s.rsum[3:0], h[3:0]};
                else
                    s.hex_run = 1'b0;
            end
            else if (c == CH_STAR) begin
                s.star    = 1'b1;
                s.hex_run = 1'b1;
            end
            else if (p >= POS_W'(1)) begin
                s.xsum = s.xsum ^ c;
            end

            if ((p == POS_W'(7)) || (p == POS_W'(17)) || (p == POS_W'(20)) || (p == POS_W'(23)))
                s.field_run = 1'b1;
            if (s.field_run && is_digit) begin
                if ((p >= POS_W'(7)) && (p <= POS_W'(12)))
                    s.time_bcd = {s.time_bcd[19:0], d};
                else if ((p >= POS_W'(17)) && (p <= POS_W'(18)))
                    s.day = 7'(s.day * 7'd10) + {3'b0, d};
                else if ((p >= POS_W'(20)) && (p <= POS_W'(21)))
                    s.month = 7'(s.month * 7'd10) + {3'b0, d};
                else if ((p >= POS_W'(23)) && (p <= POS_W'(26)))
                    s.year = 14'(s.year * 14'd10) + {10'b0, d};
                else
                    s.field_run = 1'b0;
            end
            else begin
                s.field_run = 1'b0;
            end
            s.pos = p + POS_W'(1);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// File: sv/nzda_front.sv
`timescale 1ns / 1ps
`default_nettype none
module nzda_front
    import nzda_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,    // rx_byte
    input  wire fifo_status_t fifo_st,
    output logic              push,
    output evt_t              evt
);

    logic last_cr_reg;
    logic last_cr_next;
    logic lf_end;
    logic xfer;

    assign s_tready = !fifo_st.full;
    assign xfer     = s_tvalid && s_tready;
    assign lf_end   = (s_tdata == CH_LF) && last_cr_reg;

    always_comb
    begin
        evt.is_end   = lf_end;
        // a held cr that is not followed by lf becomes a line character
        evt.pre_cr   = last_cr_reg && !lf_end;
        evt.has_char = !lf_end && (s_tdata != CH_CR);
        evt.data     = s_tdata;
        push         = xfer && (evt.is_end || evt.pre_cr || evt.has_char);
        last_cr_next = last_cr_reg;
        if (xfer)
            last_cr_next = (s_tdata == CH_CR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_cr_reg <= 1'b0;
        else
            last_cr_reg <= last_cr_next;
    end

endmodule
`default_nettype wire

// File: sv/nzda_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module nzda_fifo
    import nzda_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire evt_t   wr_evt,
    input  wire logic   pop,
    output evt_t        head,
    output fifo_status_t st
);

    evt_t               q_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign st.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign st.empty = (count_reg == '0);
    assign do_push  = push && !st.full;
    assign do_pop   = pop && !st.empty;
    assign head     = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + FIFO_AW'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + FIFO_AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + FIFO_CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= wr_evt;
    end

endmodule
`default_nettype wire

// File: sv/nzda_back.sv
`timescale 1ns / 1ps
`default_nettype none
module nzda_back
    import nzda_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire evt_t         head,
    input  wire fifo_status_t fifo_st,
    output logic              pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    line_t             line_reg, line_next;
    line_t             after_cr;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;
    status_t           status;
    logic              emit;
    logic [6:0]        hour, minute, second, day, month;
    logic [13:0]       year;
    logic [7:0]        csum;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // an end event waits for room in the output register, line characters never wait
    assign pop = !fifo_st.empty && (!head.is_end || !out_valid_reg || m_tready);

    always_comb
    begin
        emit = (line_reg.pos != '0) || line_reg.ovf;
        if (line_reg.ovf)
            status = ST_OVERFLOW;
        else if ((line_reg.pos < POS_W'(7)) || !line_reg.hdr_ok)
            status = ST_UNKNOWN;
        else if (!line_reg.star || (line_reg.rsum != line_reg.xsum))
            status = ST_CHECKSUM;
        else if (line_reg.no_fix)
            status = ST_NOFIX;
        else
            status = ST_OK;

        hour   = '0;
        minute = '0;
        second = '0;
        day    = '0;
        month  = '0;
        year   = '0;
        csum   = '0;
        if (status == ST_OK)
        begin
            hour   = bcd2bin(line_reg.time_bcd[23:16]);
            minute = bcd2bin(line_reg.time_bcd[15:8]);
            second = bcd2bin(line_reg.time_bcd[7:0]);
            day    = line_reg.day;
            month  = line_reg.month;
            year   = line_reg.year;
        end
        if ((status == ST_OK) || (status == ST_CHECKSUM) || (status == ST_NOFIX))
            csum = line_reg.xsum;
    end

    always_comb
    begin
        after_cr       = head.pre_cr ? take_char(line_reg, CH_CR) : line_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            if (head.is_end)
            begin
                line_next = line_reset();
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, csum, year, month, day, second, minute, hour,
                                      status};
                end
            end
            else if (head.has_char)
                line_next = take_char(after_cr, head.data);
            else
                line_next = after_cr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= line_reset();
            out_valid_reg <= 1'b0;
        end
        else
        begin
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

// File: sv/nmea_zda_time_parser.sv
// throughput: one byte per cycle while the event queue has room; a line character
//   never waits on the output side; an lf event is queued, popped by the line engine
//   after older bytes drain, and its result registered when the output has room
// a full four-entry event queue drops s_tready until the line engine pops
// reset: rst_n asynchronous active low, clears the framer, queue, line state and output
`timescale 1ns / 1ps
`default_nettype none
module nmea_zda_time_parser
    import nzda_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,    // rx_byte
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // status[2:0], hour[9:3], minute[16:10], second[23:17], day[30:24],
    // month[37:31], year[51:38], computed_sum[59:52], zero fill[63:60]
    output logic [OUT_W-1:0]      m_tdata
);

    fifo_status_t fifo_st;
    evt_t         wr_evt;
    evt_t         head;
    logic         push;
    logic         pop;

    nzda_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .fifo_st  (fifo_st),
        .push     (push),
        .evt      (wr_evt)
    );

    nzda_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_evt (wr_evt),
        .pop    (pop),
        .head   (head),
        .st     (fifo_st)
    );

    nzda_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .fifo_st  (fifo_st),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    a_fifo_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_st.full && fifo_st.empty))
        else $error("queue full and empty at once");

    a_rise_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(pop && head.is_end))
        else $error("result without a line end");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= ST_OVERFLOW))
        else $error("status code out of range");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] != ST_OK)) |-> (m_tdata[51:3] == '0))
        else $error("time fields set on a failed line");
`endif

endmodule
`default_nettype wire

// File: dv/zda_result_checker.sv
`timescale 1ns / 1ps
module zda_result_checker
    import nzda_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    output int               mismatches,
    output int               fixes_waiting
);

    typedef struct packed {
        status_t     status;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
        logic [7:0]  csum;
    } zda_fix_t;

    zda_fix_t expected_fixes[$];

    // line state of the predicted parser
    int unsigned ln_pos;
    logic [7:0]  ln_xor;
    logic [7:0]  ln_rsum;
    bit          ln_star;
    bit          ln_hdr_ok;
    bit          ln_nofix;
    bit          ln_ovf;
    bit          ln_field_run;
    bit          ln_hex_run;
    int unsigned ln_time;
    logic [6:0]  ln_day;
    logic [6:0]  ln_month;
    logic [13:0] ln_year;
    bit          cr_held;

    string zda_header = "$GPZDA,";

    initial mismatches = 0;
    initial fixes_waiting = 0;

    task automatic clear_line();
        ln_pos       = 0;
        ln_xor       = '0;
        ln_rsum      = '0;
        ln_star      = 1'b0;
        ln_hdr_ok    = 1'b1;
        ln_nofix     = 1'b0;
        ln_ovf       = 1'b0;
        ln_field_run = 1'b0;
        ln_hex_run   = 1'b0;
        ln_time      = 0;
        ln_day       = '0;
        ln_month     = '0;
        ln_year      = '0;
    endtask

    task automatic take_line_char(input logic [7:0] c);
        int unsigned p;
        int unsigned d;
        int unsigned h;
        bit          is_digit;
        p        = ln_pos;
        d        = c - CH_ZERO;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        h        = 16;
        if (p >= LINE_LIMIT) begin
            ln_ovf = 1'b1;
            return;
        end
        if (p < 7 && c != zda_header[p])
            ln_hdr_ok = 1'b0;
        if (p == 7 && c == CH_COMMA)
            ln_nofix = 1'b1;

        if (ln_star) begin
            if (is_digit)
                h = d;
            else if (c >= CH_UA && c <= CH_UF)
                h = c - CH_UA + 10;
            else if (c >= CH_LA && c <= CH_LFX)
                h = c - CH_LA + 10;
            if (ln_hex_run && h < 16)
                ln_rsum = {ln_rsum[3:0], 4'(h)};
            else
                ln_hex_run = 1'b0;
        end
        else if (c == CH_STAR) begin
            ln_star    = 1'b1;
            ln_hex_run = 1'b1;
        end
        else if (p >= 1) begin
            ln_xor = ln_xor ^ c;
        end

        if (p == 7 || p == 17 || p == 20 || p == 23)
            ln_field_run = 1'b1;
        if (ln_field_run && is_digit) begin
            if (p >= 7 && p <= 12)
                ln_time = ln_time * 10 + d;
            else if (p >= 17 && p <= 18)
                ln_day = 7'(ln_day * 10 + d);
            else if (p >= 20 && p <= 21)
                ln_month = 7'(ln_month * 10 + d);
            else if (p >= 23 && p <= 26)
                ln_year = 14'(ln_year * 10 + d);
            else
                ln_field_run = 1'b0;
        end
        else begin
            ln_field_run = 1'b0;
        end
        ln_pos = p + 1;
    endtask

    task automatic close_line();
        zda_fix_t fx;
        if (ln_pos == 0 && !ln_ovf)
            return;
        fx = '0;
        if (ln_ovf)
            fx.status = ST_OVERFLOW;
        else if (ln_pos < 7 || !ln_hdr_ok)
            fx.status = ST_UNKNOWN;
        else if (!ln_star || ln_rsum != ln_xor)
            fx.status = ST_CHECKSUM;
        else if (ln_nofix)
            fx.status = ST_NOFIX;
        else
            fx.status = ST_OK;
        if (fx.status == ST_OK) begin
            fx.hour   = 7'(ln_time / 10000);
            fx.minute = 7'((ln_time / 100) % 100);
            fx.second = 7'(ln_time % 100);
            fx.day    = ln_day;
            fx.month  = ln_month;
            fx.year   = ln_year;
        end
        if (fx.status == ST_OK || fx.status == ST_CHECKSUM || fx.status == ST_NOFIX)
            fx.csum = ln_xor;
        expected_fixes.push_back(fx);
        clear_line();
    endtask

    // cr is held until the next byte shows whether it ends the line
    task automatic feed_rx_byte(input logic [7:0] c);
        if (c == CH_LF && cr_held) begin
            cr_held = 1'b0;
            close_line();
        end
        else begin
            if (cr_held) begin
                take_line_char(CH_CR);
                cr_held = 1'b0;
            end
            if (c == CH_CR)
                cr_held = 1'b1;
            else
                take_line_char(c);
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        zda_fix_t fx;
        if (!rst_n) begin
            clear_line();
            cr_held = 1'b0;
            expected_fixes.delete();
        end
        else begin
            if (s_tvalid && s_tready)
                feed_rx_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_fixes.size() == 0) begin
                    $error("result transfer with no line end pending, data %h", m_tdata);
                    mismatches++;
                end
                else begin
                    fx = expected_fixes.pop_front();
                    check_field("status", fx.status, m_tdata[2:0]);
                    check_field("hour", fx.hour, m_tdata[9:3]);
                    check_field("minute", fx.minute, m_tdata[16:10]);
                    check_field("second", fx.second, m_tdata[23:17]);
                    check_field("day", fx.day, m_tdata[30:24]);
                    check_field("month", fx.month, m_tdata[37:31]);
                    check_field("year", fx.year, m_tdata[51:38]);
                    check_field("computed_sum", fx.csum, m_tdata[59:52]);
                end
            end
        end
        fixes_waiting <= expected_fixes.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import nzda_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    int mismatches;
    int fixes_waiting;

    logic [7:0] line_buf[$];
    int  burst_left  = 0;
    int  bytes_sent  = 0;
    bit  gaps_on     = 1'b1;
    bit  rx_stalls   = 1'b1;
    int  rdy_left    = 0;
    int  stall_left  = 0;

    nmea_zda_time_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    zda_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .fixes_waiting (fixes_waiting)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: ready runs broken by short stalls and now and then a long one while rx_stalls is set
    always @(posedge clk) begin
        logic nxt;
        if (!rst_n) begin
            nxt = 1'b0;
        end
        else if (rdy_left > 0) begin
            rdy_left--;
            nxt = 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b0;
        end
        else begin
            rdy_left = $urandom_range(1, 30);
            if (!rx_stalls)
                stall_left = 0;
            else if ($urandom_range(0, 9) == 0)
                stall_left = $urandom_range(10, 40);
            else
                stall_left = $urandom_range(1, 4);
            nxt = 1'b1;
        end
        m_tready <= nxt;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        send_byte(CH_CR);
        send_byte(CH_LF);
        line_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_dec(input int v, input int n);
        int div;
        div = 1;
        repeat (n - 1) div *= 10;
        repeat (n) begin
            line_buf.push_back(8'(CH_ZERO + (v / div) % 10));
            div /= 10;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10)
            return 8'(CH_ZERO + n);
        return 8'((lower ? CH_LA : CH_UA) + n - 10);
    endfunction

    // xor from the second character up to the first star
    function automatic logic [7:0] body_xor();
        logic [7:0] x;
        x = '0;
        for (int i = 1; i < line_buf.size(); i++) begin
            if (line_buf[i] == CH_STAR)
                break;
            x ^= line_buf[i];
        end
        return x;
    endfunction

    // mode 0 good sum, 1 bad sum, 2 no star, 3 good sum with a leading zero digit
    task automatic add_sum(input int mode, input bit lower);
        logic [7:0] x;
        x = body_xor();
        if (mode == 1)
            x ^= 8'($urandom_range(1, 255));
        if (mode != 2) begin
            line_buf.push_back(CH_STAR);
            if (mode == 3)
                line_buf.push_back(CH_ZERO);
            line_buf.push_back(hex_char(x[7:4], lower));
            line_buf.push_back(hex_char(x[3:0], lower));
        end
    endtask

    task automatic build_zda(input int hh, input int mi, input int ss,
                             input int dd, input int mo, input int yy);
        line_buf.delete();
        add_text("$GPZDA,");
        add_dec(hh, 2);
        add_dec(mi, 2);
        add_dec(ss, 2);
        add_text(".");
        add_dec($urandom_range(0, 99), 2);
        add_text(",");
        add_dec(dd, 2);
        add_text(",");
        add_dec(mo, 2);
        add_text(",");
        add_dec(yy, 4);
        add_text(",00,00");
    endtask

    function automatic int pick_2digit();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 99;
            default: return $urandom_range(0, 99);
        endcase
    endfunction

    task automatic build_random_zda();
        build_zda(pick_2digit(), pick_2digit(), pick_2digit(), pick_2digit(),
                  pick_2digit(), ($urandom_range(0, 7) == 0) ? 9999 : $urandom_range(0, 9999));
    endtask

    task automatic build_long(input int n);
        line_buf.delete();
        add_text("$GPZDA,");
        repeat (n) line_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
    endtask

    task automatic build_noise(input int n);
        line_buf.delete();
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic random_line();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            build_random_zda();
            // now and then a stray character inside the digit fields
            if ($urandom_range(0, 9) == 0)
                line_buf[$urandom_range(7, 26)] = 8'($urandom_range(8'h20, 8'h7e));
            add_sum(($urandom_range(0, 9) == 0) ? 3 : 0, $urandom_range(0, 1));
        end
        else if (kind < 68) begin
            build_random_zda();
            add_sum(1, $urandom_range(0, 1));
        end
        else if (kind < 72) begin
            build_random_zda();
            add_sum(2, 1'b0);
        end
        else if (kind < 78) begin
            line_buf.delete();
            add_text("$GPZDA,,,,,,");
            add_sum(0, $urandom_range(0, 1));
        end
        else if (kind < 84) begin
            build_random_zda();
            line_buf[$urandom_range(0, 6)] = 8'($urandom_range(0, 255));
            add_sum(0, 1'b0);
        end
        else if (kind < 88) begin
            line_buf.delete();
            add_text("$GPZDA,");
            line_buf = line_buf[0:$urandom_range(0, 5)];
        end
        else if (kind < 91) begin
            build_long($urandom_range(110, 140));
            add_sum(0, 1'b0);
        end
        else if (kind < 94) begin
            line_buf.delete();
        end
        else if (kind < 97) begin
            build_noise($urandom_range(1, 20));
        end
        else begin
            // lone lf and a cr that does not end the line
            build_random_zda();
            line_buf.push_back(CH_LF);
            line_buf.push_back(CH_CR);
            add_text("7");
            add_sum(0, 1'b1);
        end
        send_line();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines
        build_zda(99, 99, 99, 99, 99, 9999);
        add_sum(0, 1'b0);
        send_line();
        build_zda(0, 0, 0, 0, 0, 0);
        add_sum(0, 1'b1);
        send_line();
        build_zda(12, 34, 56, 1, 12, 2024);
        add_sum(1, 1'b0);
        send_line();
        build_zda(12, 34, 56, 1, 12, 2024);
        add_sum(2, 1'b0);
        send_line();
        line_buf.delete();
        add_text("$GPZDA,,,,,,");
        add_sum(0, 1'b0);
        send_line();
        line_buf.delete();
        add_text("$GPRMC,123456.00,01,12,2024,00,00");
        add_sum(0, 1'b0);
        send_line();
        line_buf.delete();
        add_text("$GP");
        send_line();
        send_line();
        // field that starts with a non-digit
        build_zda(12, 34, 56, 1, 12, 2024);
        line_buf[7] = "x";
        add_sum(3, 1'b1);
        send_line();
        // exactly at the line limit, then one character over
        build_long(LINE_LIMIT - 7);
        send_line();
        build_long(LINE_LIMIT - 6);
        send_line();
        build_zda(1, 2, 3, 4, 5, 6);
        line_buf.push_back(CH_LF);
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_CR);
        add_sum(0, 1'b0);
        send_line();
        line_buf.delete();
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hff);
        line_buf.push_back(CH_CR);
        send_line();

        while (bytes_sent < 1300) begin
            if ($urandom_range(0, 7) == 0) begin
                gaps_on   = $urandom_range(0, 1);
                rx_stalls <= $urandom_range(0, 1);
            end
            random_line();
        end
        s_tvalid <= 1'b0;

        // let the count of pending results catch up with the last transfer
        @(posedge clk);
        while (fixes_waiting != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && fixes_waiting == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: nmea_zda_time_parser.f
sv/nzda_pkg.sv
sv/nzda_front.sv
sv/nzda_fifo.sv
sv/nzda_back.sv
sv/nmea_zda_time_parser.sv
dv/zda_result_checker.sv
dv/testbench.sv
